// ----- rtl/tasq_pkg.sv -----
// Shared types, codes and helpers for the two-axis step command queue.
package tasq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    // frame letters
    localparam logic [7:0] MOTOR_X = 8'h58;  // 'X'
    localparam logic [7:0] MOTOR_Y = 8'h59;  // 'Y'
    localparam logic [7:0] DIR_C_UP = 8'h43;  // 'C'
    localparam logic [7:0] DIR_C_LO = 8'h63;  // 'c'
    localparam logic [7:0] DIR_N_UP = 8'h4E;  // 'N'
    localparam logic [7:0] DIR_N_LO = 8'h6E;  // 'n'

    // byte slot within a four-byte frame
    localparam logic [1:0] POS_MOTOR = 2'd0;
    localparam logic [1:0] POS_DIR   = 2'd1;
    localparam logic [1:0] POS_LOW   = 2'd2;
    localparam logic [1:0] POS_HIGH  = 2'd3;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_CMP_A = 2'd1,
        CMD_CMP_B = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [7:0]  dir;
        logic [15:0] steps;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    // C/c drives the pin high, N/n low, any other letter keeps it
    function automatic logic dir_level(input logic [7:0] letter, input logic cur);
        logic lvl;
        lvl = cur;
        if (letter == DIR_C_UP || letter == DIR_C_LO) begin
            lvl = 1'b1;
        end else if (letter == DIR_N_UP || letter == DIR_N_LO) begin
            lvl = 1'b0;
        end
        return lvl;
    endfunction

endpackage

// ----- rtl/tasq_fifo.sv -----
// Ring-buffer command FIFO with a registered head read and push bypass.
module tasq_fifo #(
    parameter int QUEUE_DEPTH = tasq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tasq_pkg::t_q_ctl                   i_ctl,
    input  tasq_pkg::t_entry                   i_wr_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output tasq_pkg::t_entry                   o_head
);
    import tasq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_head_q;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;

    always_comb begin
        tail_sum = {1'b0, r_head} + (AW + 1)'(r_count);
        tail = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        n_head = r_head;
        if (i_ctl.pop) begin
            n_head = (r_head == LAST_A) ? '0 : r_head + AW'(1);
        end
        n_count = r_count + CW'(i_ctl.push) - CW'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[tail] <= i_wr_data;
        end
    end

    // prefetch the next head; forward a word written to that slot this cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && tail == n_head) begin
            r_head_q <= i_wr_data;
        end else begin
            r_head_q <= r_mem[n_head];
        end
    end

    // an empty queue can only pop the word pushed in the same cycle
    assign o_head  = (r_count == '0) ? i_wr_data : r_head_q;
    assign o_count = r_count;

endmodule

// ----- rtl/two_axis_step_command_queue.sv -----
// Two-axis step/direction command queue: top level.
// Each accepted word is a serial byte (tuser 0) or a timer compare event
// (tuser 1 = compare A, 2 = compare B, 3 = no event). Four bytes form a
// frame: motor letter X or Y, direction letter, step count low byte, high
// byte; a complete frame goes into that axis's FIFO of QUEUE_DEPTH entries,
// and a frame for an unknown motor or a full FIFO is dropped and flagged.
// When both axes have no steps left, the head of each non-empty FIFO loads.
// Compare A drives the pulse pin of a stepping axis low, compare B drives it
// high and counts one step. Every accepted word gives one result word with
// the pin levels, step counts, FIFO fill levels, busy and drop flags. The
// block takes one word per clock unless the output stalls; all work on it is
// done in its accept cycle, with FIFO heads read from a registered prefetch.
module two_axis_step_command_queue #(
    parameter int QUEUE_DEPTH = tasq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] x_pulse, [1] y_pulse, [2] x_direction, [3] y_direction,
    // [19:4] x_steps_left, [35:20] y_steps_left, [41:36] x_queued,
    // [47:42] y_queued, [48] busy_res, [49] frame_dropped, [55:50] zero
    output logic [55:0] o_m_tdata
);
    import tasq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic        accept;
    t_cmd        cmd;
    logic [7:0]  rx_byte;

    logic [1:0]  r_pos, n_pos;
    logic [7:0]  r_motor, n_motor;
    logic [7:0]  r_dir, n_dir;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_x_rem, n_x_rem;
    logic [15:0] r_y_rem, n_y_rem;
    logic        r_x_pulse, n_x_pulse;
    logic        r_y_pulse, n_y_pulse;
    logic        r_x_dir, n_x_dir;
    logic        r_y_dir, n_y_dir;
    logic        r_dropped, n_dropped;
    logic        r_valid, n_valid;

    logic [15:0] x_rem_t, y_rem_t;
    logic        frame_done;
    logic        x_nz, y_nz, load;
    t_q_ctl      x_ctl, y_ctl;
    t_entry      frame_entry, x_head, y_head;
    logic [CW-1:0] x_count, y_count;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_valid || i_m_tready;
    assign cmd        = t_cmd'(i_s_tuser);
    assign rx_byte    = i_s_tdata;

    assign frame_entry = '{dir: r_dir, steps: {rx_byte, r_low}};

    always_comb begin
        n_pos     = r_pos;
        n_motor   = r_motor;
        n_dir     = r_dir;
        n_low     = r_low;
        x_rem_t   = r_x_rem;
        y_rem_t   = r_y_rem;
        n_x_pulse = r_x_pulse;
        n_y_pulse = r_y_pulse;
        frame_done = 1'b0;

        if (accept) begin
            case (cmd)
                CMD_BYTE: begin
                    case (r_pos)
                        POS_MOTOR: begin
                            n_motor = rx_byte;
                            n_pos   = POS_DIR;
                        end
                        POS_DIR: begin
                            n_dir = rx_byte;
                            n_pos = POS_LOW;
                        end
                        POS_LOW: begin
                            n_low = rx_byte;
                            n_pos = POS_HIGH;
                        end
                        default: begin
                            frame_done = 1'b1;
                            n_pos   = POS_MOTOR;
                            n_motor = '0;
                            n_dir   = '0;
                            n_low   = '0;
                        end
                    endcase
                end
                CMD_CMP_A: begin
                    if (r_x_rem != '0) n_x_pulse = 1'b0;
                    if (r_y_rem != '0) n_y_pulse = 1'b0;
                end
                CMD_CMP_B: begin
                    if (r_x_rem != '0) begin
                        n_x_pulse = 1'b1;
                        x_rem_t   = r_x_rem - 16'd1;
                    end
                    if (r_y_rem != '0) begin
                        n_y_pulse = 1'b1;
                        y_rem_t   = r_y_rem - 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        x_ctl.push = frame_done && r_motor == MOTOR_X && x_count != FULL_CNT;
        y_ctl.push = frame_done && r_motor == MOTOR_Y && y_count != FULL_CNT;
        n_dropped  = frame_done && !x_ctl.push && !y_ctl.push;

        // load new commands once both axes are idle
        x_nz = x_count != '0 || x_ctl.push;
        y_nz = y_count != '0 || y_ctl.push;
        load = accept && x_rem_t == '0 && y_rem_t == '0 && (x_nz || y_nz);
        x_ctl.pop = load && x_nz;
        y_ctl.pop = load && y_nz;

        n_x_rem = x_ctl.pop ? x_head.steps : x_rem_t;
        n_y_rem = y_ctl.pop ? y_head.steps : y_rem_t;
        n_x_dir = x_ctl.pop ? dir_level(x_head.dir, r_x_dir) : r_x_dir;
        n_y_dir = y_ctl.pop ? dir_level(y_head.dir, r_y_dir) : r_y_dir;

        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_MOTOR;
            r_motor   <= '0;
            r_dir     <= '0;
            r_low     <= '0;
            r_x_rem   <= '0;
            r_y_rem   <= '0;
            r_x_pulse <= 1'b0;
            r_y_pulse <= 1'b0;
            r_x_dir   <= 1'b0;
            r_y_dir   <= 1'b0;
            r_dropped <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_motor   <= n_motor;
            r_dir     <= n_dir;
            r_low     <= n_low;
            r_x_rem   <= n_x_rem;
            r_y_rem   <= n_y_rem;
            r_x_pulse <= n_x_pulse;
            r_y_pulse <= n_y_pulse;
            r_x_dir   <= n_x_dir;
            r_y_dir   <= n_y_dir;
            r_valid   <= n_valid;
            if (accept) begin
                r_dropped <= n_dropped;
            end
        end
    end

    tasq_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_x_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (x_ctl),
        .i_wr_data (frame_entry),
        .o_count   (x_count),
        .o_head    (x_head)
    );

    tasq_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_y_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (y_ctl),
        .i_wr_data (frame_entry),
        .o_count   (y_count),
        .o_head    (y_head)
    );

    // state is frozen while a result word waits, so it doubles as the output
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_dropped, (r_x_rem != '0 || r_y_rem != '0),
                         6'(y_count), 6'(x_count), r_y_rem, r_x_rem,
                         r_y_dir, r_x_dir, r_y_pulse, r_x_pulse};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_count <= FULL_CNT && y_count <= FULL_CNT)
        else $error("FIFO count beyond depth");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cmd == CMD_BYTE && r_pos == POS_HIGH |=> r_pos == POS_MOTOR)
        else $error("frame position did not wrap after high byte");

    a_drop_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !(cmd == CMD_BYTE && r_pos == POS_HIGH) |=> !r_dropped)
        else $error("drop flag without a completed frame");

    a_x_steps_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cmd != CMD_CMP_B && r_x_rem != '0 |=> r_x_rem == $past(r_x_rem))
        else $error("X step count changed without compare B");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_x_rem) && $stable(r_y_rem) && $stable(r_pos))
        else $error("state changed without an accepted word");

endmodule
